@@ rtl/rcdh_pkg.sv @@
package rcdh_pkg;

    localparam int MAP_BITS  = 10;
    localparam int FRAC_BITS = 16;

    localparam int POS_W  = MAP_BITS + FRAC_BITS;
    localparam int DIR_W  = FRAC_BITS + 2;
    localparam int CELL_W = MAP_BITS;
    localparam int NUM_W  = POS_W + 2;          // signed numerator
    localparam int DEN_W  = DIR_W + 1;          // denominator / divisor magnitude
    localparam int PROD_W = NUM_W + DIR_W;      // signed product
    localparam int QUO_W  = NUM_W + DIR_W - 1;  // dividend / quotient magnitude
    localparam int SUM_W  = QUO_W + 2;          // signed intersection coordinate
    localparam int DIST_W = 32;
    localparam int LANES  = 3;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_D = 2;

    localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0] SUM_ONE = SUM_W'(1) << FRAC_BITS;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef struct packed {
        logic              zero;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [LANES-1:0]  neg;
    } t_side;

    typedef struct packed {
        logic                        valid;
        t_side                       side;
        logic [DEN_W-1:0]            dvs;
        logic [LANES-1:0][DEN_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] dvd;
    } t_div;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [DIST_W-1:0] hit_dist;
        logic [POS_W-1:0]  hx;
        logic [POS_W-1:0]  hy;
    } t_res;

endpackage

@@ rtl/ray_cell_diagonal_hit.sv @@
// Ray versus diagonal-wall test for one grid cell.
// Input channel: i_valid / o_stall with the ray origin (Q10.16), direction
// (signed Q2.16), cell column/row and diagonal select. A transaction is
// taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with hit flag, saturated Q15.16 distance
// and the clamped intersection point; all zero when there is no hit.
// Every input transaction yields exactly one output transaction, in order.
// Throughput: one transaction per cycle while o_stall is low. The pipeline has
// 50 register stages: 3 setup/multiply stages, one stage per quotient bit of
// the 45-bit radix-2 divider that runs x, y and distance in parallel lanes,
// one sign/saturate stage and one output register.
// The whole pipeline advances on one enable. A skid register behind the
// output register catches the item that leaves the pipe when the receiver
// stalls; o_stall is raised only while the skid is occupied, so new input
// keeps flowing while a single result waits.
// Reset (synchronous, active low) clears all valid bits, skid and output;
// items in flight are dropped.
module ray_cell_diagonal_hit
    import rcdh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [POS_W-1:0]  i_pos_x,
    input  logic [POS_W-1:0]  i_pos_y,
    input  logic [DIR_W-1:0]  i_dir_x,
    input  logic [DIR_W-1:0]  i_dir_y,
    input  logic [CELL_W-1:0] i_cell_x,
    input  logic [CELL_W-1:0] i_cell_y,
    input  logic              i_diagonal,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_hit,
    output logic [DIST_W-1:0] o_distance,
    output logic [POS_W-1:0]  o_hit_x,
    output logic [POS_W-1:0]  o_hit_y
);

    logic w_en;
    t_div w_div [QUO_W+1];
    t_res w_last;
    t_res r_out, r_skid;

    // pipe moves whenever the skid is free
    assign w_en    = !r_skid.valid;
    assign o_stall = r_skid.valid;

    rcdh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_valid),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_cell_x   (i_cell_x),
        .i_cell_y   (i_cell_y),
        .i_diagonal (i_diagonal),
        .o_div      (w_div[0])
    );

    // one quotient bit per stage
    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        rcdh_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_div   (w_div[g]),
            .o_div   (w_div[g+1])
        );
    end

    rcdh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_div   (w_div[QUO_W]),
        .o_res   (w_last)
    );

    // output register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (r_skid.valid) begin
            if (!i_stall) begin
                r_out        <= r_skid;
                r_skid.valid <= 1'b0;
            end
        end else if (!r_out.valid || !i_stall) begin
            r_out <= w_last;
        end else begin
            r_skid <= w_last;
        end
    end

    assign o_valid    = r_out.valid;
    assign o_hit      = r_out.hit;
    assign o_distance = r_out.hit_dist;
    assign o_hit_x    = r_out.hx;
    assign o_hit_y    = r_out.hy;

endmodule

@@ rtl/rcdh_front.sv @@
module rcdh_front
    import rcdh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [POS_W-1:0]  i_pos_x,
    input  logic [POS_W-1:0]  i_pos_y,
    input  logic [DIR_W-1:0]  i_dir_x,
    input  logic [DIR_W-1:0]  i_dir_y,
    input  logic [CELL_W-1:0] i_cell_x,
    input  logic [CELL_W-1:0] i_cell_y,
    input  logic              i_diagonal,
    output t_div              o_div
);

    // stage 1: numerator / denominator
    logic [NUM_W-1:0] n_num, w_cxs, w_cys, w_px, w_py;
    logic [DEN_W-1:0] n_den, w_dx, w_dy, w_dsum;
    logic             n_zero;

    logic                     r1_valid, r1_zero;
    logic signed [NUM_W-1:0]  r1_num;
    logic signed [DEN_W-1:0]  r1_den;
    logic signed [DIR_W-1:0]  r1_dx, r1_dy;
    logic [POS_W-1:0]         r1_px, r1_py;
    logic [CELL_W-1:0]        r1_cx, r1_cy;

    always_comb begin
        w_cxs  = NUM_W'({i_cell_x, {FRAC_BITS{1'b0}}});
        w_cys  = NUM_W'({i_cell_y, {FRAC_BITS{1'b0}}});
        w_px   = NUM_W'(i_pos_x);
        w_py   = NUM_W'(i_pos_y);
        w_dx   = DEN_W'($signed(i_dir_x));
        w_dy   = DEN_W'($signed(i_dir_y));
        w_dsum = w_dx + w_dy;
        if (i_diagonal) begin
            n_num = w_cxs + w_cys + NUM_ONE - w_px - w_py;
            n_den = w_dsum;
        end else begin
            n_num = w_cys - w_cxs - w_py + w_px;
            n_den = w_dy - w_dx;
        end
        n_zero = (n_den == '0) || (w_dsum == '0);
    end

    // stage 2: products
    logic                     r2_valid, r2_zero;
    logic signed [PROD_W-1:0] r2_p [LANES];
    logic signed [DEN_W-1:0]  r2_den;
    logic [POS_W-1:0]         r2_px, r2_py;
    logic [CELL_W-1:0]        r2_cx, r2_cy;

    // stage 3: magnitudes and quotient signs
    t_div r3;
    t_div n3;

    always_comb begin
        logic [PROD_W-1:0] mag;
        mag = '0;
        n3 = '0;
        n3.valid   = r2_valid;
        n3.side.zero = r2_zero;
        n3.side.px = r2_px;
        n3.side.py = r2_py;
        n3.side.cx = r2_cx;
        n3.side.cy = r2_cy;
        n3.dvs     = r2_den[DEN_W-1] ? DEN_W'(-r2_den) : DEN_W'(r2_den);
        for (int l = 0; l < LANES; l++) begin
            mag = r2_p[l][PROD_W-1] ? PROD_W'(-r2_p[l]) : PROD_W'(r2_p[l]);
            n3.dvd[l]      = mag[QUO_W-1:0];
            n3.rem[l]      = '0;
            n3.side.neg[l] = r2_p[l][PROD_W-1] ^ r2_den[DEN_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3.valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3.valid <= n3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_num  <= $signed(n_num);
            r1_den  <= $signed(n_den);
            r1_zero <= n_zero;
            r1_dx   <= $signed(i_dir_x);
            r1_dy   <= $signed(i_dir_y);
            r1_px   <= i_pos_x;
            r1_py   <= i_pos_y;
            r1_cx   <= i_cell_x;
            r1_cy   <= i_cell_y;

            // operands widened first so the product keeps its full width
            r2_p[LANE_X] <= PROD_W'(r1_num) * PROD_W'(r1_dx);
            r2_p[LANE_Y] <= PROD_W'(r1_num) * PROD_W'(r1_dy);
            r2_p[LANE_D] <= PROD_W'(r1_num) <<< FRAC_BITS;
            r2_den  <= r1_den;
            r2_zero <= r1_zero;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;

            r3.side <= n3.side;
            r3.dvs  <= n3.dvs;
            r3.rem  <= n3.rem;
            r3.dvd  <= n3.dvd;
        end
    end

    assign o_div = r3;

endmodule

@@ rtl/rcdh_div_stage.sv @@
module rcdh_div_stage
    import rcdh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_div,
    output t_div o_div
);

    // one restoring step per lane, shared divisor
    t_div n_div;
    t_div r_div;

    always_comb begin
        logic [DEN_W:0] sh;
        logic           ge;
        sh = '0;
        ge = 1'b0;
        n_div = i_div;
        for (int l = 0; l < LANES; l++) begin
            sh = {i_div.rem[l], i_div.dvd[l][QUO_W-1]};
            ge = sh >= {1'b0, i_div.dvs};
            n_div.rem[l] = ge ? DEN_W'(sh - {1'b0, i_div.dvs}) : sh[DEN_W-1:0];
            n_div.dvd[l] = {i_div.dvd[l][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
        end else if (i_en) begin
            r_div.valid <= n_div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div.side <= n_div.side;
            r_div.dvs  <= n_div.dvs;
            r_div.rem  <= n_div.rem;
            r_div.dvd  <= n_div.dvd;
        end
    end

    assign o_div = r_div;

endmodule

@@ rtl/rcdh_back.sv @@
module rcdh_back
    import rcdh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_div,
    output t_res o_res
);

    localparam logic signed [SUM_W-1:0] DIST_MAX = SUM_W'(32'sh7fffffff);
    localparam logic signed [SUM_W-1:0] DIST_MIN = -SUM_W'(33'sh80000000);

    logic signed [SUM_W-1:0] n_ix, n_iy, w_qd;
    logic [DIST_W-1:0]       n_dist;

    logic                    r_valid, r_zero;
    logic signed [SUM_W-1:0] r_ix, r_iy;
    logic [DIST_W-1:0]       r_dist;
    logic [CELL_W-1:0]       r_cx, r_cy;

    function automatic logic signed [SUM_W-1:0] apply_sign(input logic [QUO_W-1:0] q,
                                                         input logic neg);
        logic signed [SUM_W-1:0] v;
        v = $signed(SUM_W'(q));
        return neg ? -v : v;
    endfunction

    always_comb begin
        n_ix = $signed(SUM_W'(i_div.side.px))
             + apply_sign(i_div.dvd[LANE_X], i_div.side.neg[LANE_X]);
        n_iy = $signed(SUM_W'(i_div.side.py))
             + apply_sign(i_div.dvd[LANE_Y], i_div.side.neg[LANE_Y]);
        w_qd = apply_sign(i_div.dvd[LANE_D], i_div.side.neg[LANE_D]);
        if (w_qd > DIST_MAX) begin
            n_dist = DIST_W'(DIST_MAX);
        end else if (w_qd < DIST_MIN) begin
            n_dist = DIST_W'(DIST_MIN);
        end else begin
            n_dist = w_qd[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= i_div.side.zero;
            r_ix   <= n_ix;
            r_iy   <= n_iy;
            r_dist <= n_dist;
            r_cx   <= i_div.side.cx;
            r_cy   <= i_div.side.cy;
        end
    end

    // cell bounds check and clamp
    logic signed [SUM_W-1:0] w_lox, w_loy;
    logic                    w_hit;

    always_comb begin
        w_lox = $signed(SUM_W'({r_cx, {FRAC_BITS{1'b0}}}));
        w_loy = $signed(SUM_W'({r_cy, {FRAC_BITS{1'b0}}}));
        w_hit = !r_zero
              && (r_ix >= w_lox) && (r_ix <= w_lox + $signed(SUM_ONE))
              && (r_iy >= w_loy) && (r_iy <= w_loy + $signed(SUM_ONE));
        o_res.valid    = r_valid;
        o_res.hit      = w_hit;
        o_res.hit_dist = w_hit ? r_dist : '0;
        if (!w_hit) begin
            o_res.hx = '0;
        end else if (r_ix > $signed(SUM_W'(POS_MAX))) begin
            o_res.hx = POS_MAX;
        end else begin
            o_res.hx = r_ix[POS_W-1:0];
        end
        if (!w_hit) begin
            o_res.hy = '0;
        end else if (r_iy > $signed(SUM_W'(POS_MAX))) begin
            o_res.hy = POS_MAX;
        end else begin
            o_res.hy = r_iy[POS_W-1:0];
        end
    end

endmodule

@@ tb/ray_cell_diagonal_hit_test.sv @@
module ray_cell_diagonal_hit_test;
    import rcdh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM      = 500;
    localparam int WATCHDOG_MAX  = 20000;  // pipe is 50 deep
    localparam int DRAIN_CYCLES  = 120;
    localparam int N_DIRECTED    = 16;

    // One query on the input side.
    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [DIR_W-1:0]  dir_x;
        logic [DIR_W-1:0]  dir_y;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic              diag;
    } t_query;

    // One answer on the output side.
    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] hit_dist;
        logic [POS_W-1:0]  hx;
        logic [POS_W-1:0]  hy;
    } t_answer;

    // Directed row: query plus an optional typed-in answer.
    typedef struct packed {
        t_query  q;
        logic    fixed;
        t_answer a;
    } t_row;

    localparam logic DIAG_MAIN = 1'b0;
    localparam logic DIAG_ANTI = 1'b1;

    localparam logic [DIR_W-1:0] DIR_ONE  = DIR_W'(1) << FRAC_BITS;
    localparam logic [DIR_W-1:0] DIR_MONE = -(DIR_W'(1) << FRAC_BITS);
    localparam logic [DIR_W-1:0] DIR_MAXP = {1'b0, {(DIR_W-1){1'b1}}};
    localparam logic [DIR_W-1:0] DIR_MINN = {1'b1, {(DIR_W-1){1'b0}}};

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [POS_W-1:0]  i_pos_x;
    logic [POS_W-1:0]  i_pos_y;
    logic [DIR_W-1:0]  i_dir_x;
    logic [DIR_W-1:0]  i_dir_y;
    logic [CELL_W-1:0] i_cell_x;
    logic [CELL_W-1:0] i_cell_y;
    logic              i_diagonal;
    logic              o_valid;
    logic              i_stall;
    logic              o_hit;
    logic [DIST_W-1:0] o_distance;
    logic [POS_W-1:0]  o_hit_x;
    logic [POS_W-1:0]  o_hit_y;

    ray_cell_diagonal_hit dut (.*);

    t_answer pending_answers[$];
    int      fail_count;
    int      idle_cycles;
    bit      stim_done;
    bit      stall_enable;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Clamp an intersection coordinate into the map range.
    function automatic logic [POS_W-1:0] clamp_coord(longint v);
        if (v < 0) return '0;
        if (v > longint'(POS_MAX)) return POS_MAX;
        return POS_W'(v);
    endfunction

    // Ray against the cell diagonal, exact integers in 1/2^FRAC_BITS units.
    function automatic t_answer diag_intersect(t_query q);
        t_answer r;
        longint  px, py, dx, dy, cx, cy, num, den, ix, iy, tpar, one;
        one = longint'(1) << FRAC_BITS;
        px  = longint'(q.pos_x);
        py  = longint'(q.pos_y);
        dx  = longint'($signed(q.dir_x));
        dy  = longint'($signed(q.dir_y));
        cx  = longint'(q.cell_x);
        cy  = longint'(q.cell_y);
        r   = '0;
        if (q.diag == DIAG_ANTI) begin
            num = (cx + cy + 1) * one - (px + py);
            den = dx + dy;
        end else begin
            num = (cy - cx) * one - (py - px);
            den = dy - dx;
        end
        // parallel line or zero direction sum: miss
        if (den == 0 || dx + dy == 0) return r;
        ix = px + (num * dx) / den;  // SV division truncates toward zero
        iy = py + (num * dy) / den;
        if (ix < cx * one || ix > cx * one + one ||
            iy < cy * one || iy > cy * one + one) return r;
        tpar = (num * one) / den;
        if (tpar > 64'sd2147483647) tpar = 64'sd2147483647;
        if (tpar < -64'sd2147483648) tpar = -64'sd2147483648;
        r.hit      = 1'b1;
        r.hit_dist = DIST_W'(tpar);
        r.hx       = clamp_coord(ix);
        r.hy       = clamp_coord(iy);
        return r;
    endfunction

    function automatic t_query mk(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                  logic [DIR_W-1:0] dx, logic [DIR_W-1:0] dy,
                                  logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
                                  logic dg);
        t_query q;
        q = '{px, py, dx, dy, cx, cy, dg};
        return q;
    endfunction

    // Random gap: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Ray aimed at a random point of a random diagonal, so most rays hit.
    function automatic t_query aimed_query();
        t_query q;
        longint one, tx, ty, px, py, s;
        one = longint'(1) << FRAC_BITS;
        q.cell_x = $urandom_range(0, 3) == 0 ? CELL_W'($urandom_range(1020, 1023))
                                             : CELL_W'($urandom);
        q.cell_y = $urandom_range(0, 3) == 0 ? CELL_W'($urandom_range(0, 3))
                                             : CELL_W'($urandom);
        q.diag   = 1'($urandom_range(0, 1));
        s  = $urandom_range(0, 65536);
        tx = longint'(q.cell_x) * one + s;
        ty = longint'(q.cell_y) * one + (q.diag == DIAG_ANTI ? one - s : s);
        q.dir_x = DIR_W'($urandom);
        q.dir_y = DIR_W'($urandom);
        // step back along the ray a random amount (or forward: negative t)
        s  = longint'($urandom_range(0, 4095)) - 1024;
        px = tx - ((longint'($signed(q.dir_x)) * s) >>> 4);
        py = ty - ((longint'($signed(q.dir_y)) * s) >>> 4);
        q.pos_x = clamp_coord(px);
        q.pos_y = clamp_coord(py);
        return q;
    endfunction

    task automatic send_query(t_query q);
        i_valid    <= 1'b1;
        i_pos_x    <= q.pos_x;
        i_pos_y    <= q.pos_y;
        i_dir_x    <= q.dir_x;
        i_dir_y    <= q.dir_y;
        i_cell_x   <= q.cell_x;
        i_cell_y   <= q.cell_y;
        i_diagonal <= q.diag;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    t_row rows[N_DIRECTED];

    initial begin
        t_answer     miss;
        t_answer     exp_a;
        t_query      q;
        logic [127:0] raw_bits;
        miss = '0;
        // answers only where they are obvious: misses and trivial hits
        rows[0]  = '{mk('0, '0, '0, '0, '0, '0, DIAG_MAIN), 1'b1, miss};          // zero dir
        rows[1]  = '{mk('0, '0, DIR_ONE, DIR_ONE, '0, '0, DIAG_MAIN), 1'b1, miss}; // parallel
        rows[2]  = '{mk('0, '0, DIR_ONE, DIR_MONE, '0, '0, DIAG_ANTI), 1'b1, miss}; // sum 0
        rows[3]  = '{mk('0, '0, DIR_ONE, DIR_MONE, '0, '0, DIAG_MAIN), 1'b1, miss}; // sum 0
        rows[4]  = '{mk('0, '0, DIR_ONE, '0, '0, '0, DIAG_MAIN), 1'b1,
                     '{1'b1, '0, '0, '0}};                                         // at origin
        rows[5]  = '{mk(POS_MAX, POS_MAX, DIR_MAXP, DIR_MINN, '1, '1, DIAG_MAIN), 1'b0, miss};
        rows[6]  = '{mk(POS_MAX, '0, DIR_MINN, DIR_MAXP, '1, '1, DIAG_ANTI), 1'b0, miss};
        rows[7]  = '{mk('0, '0, DIR_MAXP, DIR_ONE, '1, '1, DIAG_MAIN), 1'b0, miss};  // far corner
        rows[8]  = '{mk(POS_MAX, POS_MAX, DIR_MONE, '0, '1, '1, DIAG_MAIN), 1'b0, miss};
        rows[9]  = '{mk('0, '0, DIR_MINN, DIR_MINN, '1, '1, DIAG_ANTI), 1'b0, miss}; // behind
        rows[10] = '{mk(26'h0008000, 26'h0008000, 18'h00100, 18'h00001, '0, '0, DIAG_ANTI),
                     1'b0, miss};                                                  // starts on diagonal
        rows[11] = '{mk(26'h0018000, 26'h0008000, DIR_ONE, 18'h00001, '0, '0, DIAG_ANTI),
                     1'b0, miss};                                                  // negative t
        rows[12] = '{mk(26'h0001000, 26'h0000000, DIR_MONE, DIR_ONE, '0, '0, DIAG_MAIN),
                     1'b0, miss};
        rows[13] = '{mk(26'h3FF8000, 26'h3FF0000, DIR_ONE, DIR_ONE, '1, '1, DIAG_ANTI),
                     1'b0, miss};
        rows[14] = '{mk(26'h2AAAAAA, 26'h1555555, 18'h2AAAA, 18'h15555, 10'h2AA, 10'h155,
                     DIAG_MAIN), 1'b0, miss};
        rows[15] = '{mk(26'h1555555, 26'h2AAAAAA, 18'h15555, 18'h2AAAA, 10'h155, 10'h2AA,
                     DIAG_ANTI), 1'b0, miss};

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_pos_x    = '0;
        i_pos_y    = '0;
        i_dir_x    = '0;
        i_dir_y    = '0;
        i_cell_x   = '0;
        i_cell_y   = '0;
        i_diagonal = 1'b0;
        stim_done  = 1'b0;
        stall_enable = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, back to back without receiver stalls
        foreach (rows[k]) begin
            exp_a = diag_intersect(rows[k].q);
            if (rows[k].fixed && exp_a != rows[k].a)
                $display("%0t: row %0d table answer disagrees with predictor", $time, k);
            pending_answers.push_back(rows[k].fixed ? rows[k].a : exp_a);
            send_query(rows[k].q);
        end
        i_valid <= 1'b0;

        // hold off until the pipe has drained completely
        while (pending_answers.size() != 0) @(posedge i_clk);
        stall_enable <= 1'b1;

        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 9) < 7) begin
                q = aimed_query();
            end else begin
                raw_bits = {$urandom, $urandom, $urandom, $urandom};
                q = raw_bits[$bits(t_query)-1:0];
            end
            pending_answers.push_back(diag_intersect(q));
            send_query(q);
            // long bursts with no gaps in between
            if (n < 150 || n > 300) send_gap();
            if (n == 250) begin
                i_valid <= 1'b0;
                while (pending_answers.size() != 0) @(posedge i_clk);
            end
        end
        i_valid   <= 1'b0;
        stim_done <= 1'b1;
    end

    // Receiver stall: random gaps, off during the directed part.
    initial begin
        int g;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_enable) begin
                g = gap_len();
                if (g > 0) begin
                    i_stall <= 1'b1;
                    repeat (g) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                repeat ($urandom_range(0, 8)) @(posedge i_clk);
            end
        end
    end

    // Compare each output transaction with the oldest pending answer.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result hit=%0b dist=%h", $time, o_hit, o_distance);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit exp %0b got %0b", $time, want.hit, o_hit);
                    fail_count++;
                end
                if (o_distance !== want.hit_dist) begin
                    $display("%0t: distance exp %h got %h", $time, want.hit_dist, o_distance);
                    fail_count++;
                end
                if (o_hit_x !== want.hx) begin
                    $display("%0t: hit_x exp %h got %h", $time, want.hx, o_hit_x);
                    fail_count++;
                end
                if (o_hit_y !== want.hy) begin
                    $display("%0t: hit_y exp %h got %h", $time, want.hy, o_hit_y);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side, then end of run.
    initial begin
        fail_count  = 0;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (stim_done && pending_answers.size() == 0) begin
                repeat (DRAIN_CYCLES) @(posedge i_clk);
                if (pending_answers.size() != 0) fail_count++;
                if (fail_count == 0) begin
                    $display("SCOREBOARD CLEAN");
                end else begin
                    $display("SCOREBOARD MISMATCH");
                end
                $finish;
            end
        end
    end

endmodule

@@ ray_cell_diagonal_hit.f @@
rtl/rcdh_pkg.sv
rtl/rcdh_front.sv
rtl/rcdh_div_stage.sv
rtl/rcdh_back.sv
rtl/ray_cell_diagonal_hit.sv
tb/ray_cell_diagonal_hit_test.sv
